FILE: design/ordered_set_kth_largest_top_macros.svh
// assertion macros used by the ordered set top design file
`ifndef ORDERED_SET_KTH_LARGEST_TOP_MACROS_SVH
`define ORDERED_SET_KTH_LARGEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OSKL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define OSKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OSKL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define OSKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/oskl_pkg.sv
package oskl_pkg;

    // store geometry
    localparam int KEY_BITS   = 32;
    localparam int CAPACITY   = 1024;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int RANK_W     = 11;
    localparam int CMP_W      = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;

    // two-level reduction tree over the cells
    localparam int GROUP_BITS = (IDX_W + 1) / 2;
    localparam int GROUP      = 1 << GROUP_BITS;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam int PAD_CAP    = NUM_GROUPS * GROUP;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [KEY_BITS-1:0] key;
        logic [RANK_W-1:0]          rank;
    } req_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] kth_key;
        logic                       found;
        logic [1:0]                 status;
        logic [COUNT_W-1:0]         held_count;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [COUNT_W-1:0]         count;
        logic [IDX_W-1:0]           qidx;
        logic                       q_en;
        logic                       ins_en;
        logic                       rem_en;
    } cell_ctl_t;

    // reduction tree load strobes
    typedef struct packed {
        logic grp_load;
        logic fin_load;
    } red_ctl_t;

endpackage

FILE: design/oskl_cell.sv
module oskl_cell
    import oskl_pkg::*;
(
    input  logic                       clk,
    input  logic [IDX_W-1:0]           slot,
    input  cell_ctl_t                  ctl,
    input  logic signed [KEY_BITS-1:0] left_key,
    input  logic                       left_ge,
    input  logic signed [KEY_BITS-1:0] right_key,
    output logic signed [KEY_BITS-1:0] key,
    output logic                       ge,
    output logic                       eq,
    output logic [KEY_BITS-1:0]        pick
);

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic                       occupied;
    logic                       selected;

    // slot holds a live key below the fill count
    assign occupied = COUNT_W'(slot) < ctl.count;
    assign selected = ctl.q_en && (slot == ctl.qidx);

    // empty slots act as plus infinity so ge stays monotone along the row
    assign ge   = !occupied || (key_reg >= ctl.key);
    assign eq   = occupied && (key_reg == ctl.key);
    assign pick = selected ? key_reg : '0;
    assign key  = key_reg;

    // shift up on insert, shift down on remove, from the insert or remove point onward
    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en && ge)
        begin
            key_next = left_ge ? left_key : ctl.key;
        end
        else if (ctl.rem_en && ge)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

FILE: design/oskl_reduce.sv
module oskl_reduce
    import oskl_pkg::*;
(
    input  logic                       clk,
    input  red_ctl_t                   ctl,
    input  logic [PAD_CAP-1:0]         eq_vec,
    input  logic [KEY_BITS-1:0]        pick_vec [PAD_CAP],
    output logic                       hit,
    output logic signed [KEY_BITS-1:0] qkey
);

    logic [NUM_GROUPS-1:0] grp_eq_reg;
    logic [NUM_GROUPS-1:0] grp_eq_next;
    logic [KEY_BITS-1:0]   grp_key_reg  [NUM_GROUPS];
    logic [KEY_BITS-1:0]   grp_key_next [NUM_GROUPS];
    logic                  hit_reg;
    logic                  hit_next;
    logic [KEY_BITS-1:0]   qkey_reg;
    logic [KEY_BITS-1:0]   qkey_next;

    // first level: or over each group of cells
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_eq_next[g]  = 1'b0;
            grp_key_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                grp_eq_next[g]  = grp_eq_next[g] | eq_vec[g * GROUP + j];
                grp_key_next[g] = grp_key_next[g] | pick_vec[g * GROUP + j];
            end
        end
    end

    // second level: or over the group results
    always_comb
    begin
        hit_next  = |grp_eq_reg;
        qkey_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            qkey_next = qkey_next | grp_key_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.grp_load)
        begin
            grp_eq_reg  <= grp_eq_next;
            grp_key_reg <= grp_key_next;
        end
        if (ctl.fin_load)
        begin
            hit_reg  <= hit_next;
            qkey_reg <= qkey_next;
        end
    end

    assign hit  = hit_reg;
    assign qkey = qkey_reg;

endmodule

FILE: design/ordered_set_kth_largest_top.sv
// ordered set of distinct signed keys held sorted in a row of cells
// a request is accepted in idle, then the group and final levels of the registered or tree
// find duplicates and the queried key, and the apply state shifts the row and registers the
// response, holding while the response is stalled; a new request is taken only back in idle
// reset: asynchronous, clears the key count and the control state; stored keys are not cleared
`include "ordered_set_kth_largest_top_macros.svh"
module ordered_set_kth_largest_top
    import oskl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    logic               rsp_free;
    logic               apply_fire;
    logic               ins_ok;
    logic               rem_ok;
    logic               range_ok;
    logic [CMP_W-1:0]   qdiff;
    logic               full;
    logic               hit;
    logic signed [KEY_BITS-1:0] qkey;

    cell_ctl_t          cell_ctl;
    red_ctl_t           red_ctl;

    logic signed [KEY_BITS-1:0] cell_key  [CAPACITY];
    logic                       cell_ge   [CAPACITY];
    logic signed [KEY_BITS-1:0] left_key  [CAPACITY];
    logic                       left_ge   [CAPACITY];
    logic signed [KEY_BITS-1:0] right_key [CAPACITY];
    logic [PAD_CAP-1:0]         eq_vec;
    logic [KEY_BITS-1:0]        pick_vec  [PAD_CAP];

    // output slot can take a new response
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_GROUP;
                end
            end
            S_GROUP:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall        = 1'b1;
        red_ctl.grp_load = 1'b0;
        red_ctl.fin_load = 1'b0;
        apply_fire       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_GROUP:
            begin
                red_ctl.grp_load = 1'b1;
            end
            S_FINAL:
            begin
                red_ctl.fin_load = 1'b1;
            end
            S_APPLY:
            begin
                apply_fire = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // query index and range check
    assign range_ok = (req_reg.rank != '0) && (CMP_W'(req_reg.rank) <= CMP_W'(count_reg));
    assign qdiff    = CMP_W'(count_reg) - CMP_W'(req_reg.rank);
    assign full     = count_reg == COUNT_W'(CAPACITY);

    // decide the update and build the response
    always_comb
    begin
        ins_ok              = 1'b0;
        rem_ok              = 1'b0;
        count_next          = count_reg;
        rsp_next.kth_key    = '0;
        rsp_next.found      = 1'b0;
        rsp_next.status     = ST_IGNORED;
        case (req_reg.cmd)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    rsp_next.status = ST_IGNORED;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    ins_ok          = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    rsp_next.status = ST_DONE;
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    rem_ok          = 1'b1;
                    count_next      = count_reg - COUNT_W'(1);
                    rsp_next.status = ST_DONE;
                end
            end
            CMD_QUERY:
            begin
                if (range_ok)
                begin
                    rsp_next.kth_key = qkey;
                    rsp_next.found   = 1'b1;
                    rsp_next.status  = ST_DONE;
                end
                else
                begin
                    rsp_next.kth_key = '1;
                    rsp_next.status  = ST_RANGE;
                end
            end
            default:
            begin
                rsp_next.status = ST_IGNORED;
            end
        endcase
        rsp_next.held_count = count_next;
    end

    // broadcast to the cell row
    always_comb
    begin
        cell_ctl.key    = req_reg.key;
        cell_ctl.count  = count_reg;
        cell_ctl.qidx   = qdiff[IDX_W-1:0];
        cell_ctl.q_en   = (req_reg.cmd == CMD_QUERY) && range_ok;
        cell_ctl.ins_en = apply_fire && ins_ok;
        cell_ctl.rem_en = apply_fire && rem_ok;
    end

    // response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (apply_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (apply_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (apply_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // row of cells, padded with idle slots up to a whole number of groups
    genvar i;
    generate
        for (i = 0; i < PAD_CAP; i++)
        begin : g_slot
            if (i < CAPACITY)
            begin : g_cell
                if (i == 0)
                begin : g_first
                    assign left_key[i] = '0;
                    assign left_ge[i]  = 1'b0;
                end
                else
                begin : g_inner
                    assign left_key[i] = cell_key[i-1];
                    assign left_ge[i]  = cell_ge[i-1];
                end
                if (i == CAPACITY - 1)
                begin : g_last
                    assign right_key[i] = cell_key[i];
                end
                else
                begin : g_mid
                    assign right_key[i] = cell_key[i+1];
                end

                oskl_cell u_cell
                (
                    .clk       (clk),
                    .slot      (IDX_W'(i)),
                    .ctl       (cell_ctl),
                    .left_key  (left_key[i]),
                    .left_ge   (left_ge[i]),
                    .right_key (right_key[i]),
                    .key       (cell_key[i]),
                    .ge        (cell_ge[i]),
                    .eq        (eq_vec[i]),
                    .pick      (pick_vec[i])
                );
            end
            else
            begin : g_pad
                assign eq_vec[i]   = 1'b0;
                assign pick_vec[i] = '0;
            end
        end
    endgenerate

    // duplicate and query key reduction
    oskl_reduce u_reduce
    (
        .clk      (clk),
        .ctl      (red_ctl),
        .eq_vec   (eq_vec),
        .pick_vec (pick_vec),
        .hit      (hit),
        .qkey     (qkey)
    );

    `OSKL_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= COUNT_W'(CAPACITY), "count above capacity")
    `OSKL_ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != S_APPLY, $stable(count_reg), "count moved outside apply")
    `OSKL_ASSERT_NEXT(a_accept_walk, clk, rst_n, req_valid && !req_stall, state_reg == S_GROUP, "accepted request did not start reduction")
    `OSKL_ASSERT_IMP(a_found_done, clk, rst_n, rsp_valid_reg && rsp_reg.found, rsp_reg.status == ST_DONE, "found without done status")
    `OSKL_ASSERT_IMP(a_one_shift, clk, rst_n, cell_ctl.ins_en, !cell_ctl.rem_en, "insert and remove shift together")

endmodule

FILE: tb/sv/tb_ordered_set_kth_largest_top.sv
`timescale 1ns / 100ps
module tb_ordered_set_kth_largest_top;
    import oskl_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [KEY_BITS-1:0] KEY_NONE = '1;
    localparam int RANK_MAX = (1 << RANK_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int MIXED_ITEMS = 30;
    localparam int FULL_ITEMS = 40;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // model of the set, ascending, plus the replies still owed by the block
    logic signed [KEY_BITS-1:0] held_keys[$];
    rsp_t pending_replies[$];
    dir_row_t directed_rows[$];
    int errors = 0;
    int cycle_count = 0;
    int burst_left = 8;
    int gap_left = 0;

    ordered_set_kth_largest_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] got,
                                   input logic [KEY_BITS-1:0] want);
        if (errors < PRINT_LIMIT)
            $display("mismatch on %s: got %0h, expected %0h, cycle %0d",
                     what, got, want, cycle_count);
        errors++;
    endtask

    // apply one request to the set model and return the reply it owes
    function automatic rsp_t apply_set_request(req_t r);
        rsp_t o;
        int p;
        int k;
        bit hit;
        o = '0;
        o.status = ST_IGNORED;
        p = 0;
        k = int'(r.rank);
        case (r.cmd)
            CMD_INSERT, CMD_REMOVE:
            begin
                while (p < held_keys.size() && held_keys[p] < $signed(r.key))
                    p++;
                hit = (p < held_keys.size()) && (held_keys[p] == $signed(r.key));
                if (r.cmd == CMD_INSERT)
                begin
                    if (hit)
                        o.status = ST_IGNORED;
                    else if (held_keys.size() >= CAPACITY)
                        o.status = ST_FULL;
                    else
                    begin
                        held_keys.insert(p, r.key);
                        o.status = ST_DONE;
                    end
                end
                else if (hit)
                begin
                    held_keys.delete(p);
                    o.status = ST_DONE;
                end
            end
            CMD_QUERY:
            begin
                if (k >= 1 && k <= held_keys.size())
                begin
                    o.kth_key = held_keys[held_keys.size() - k];
                    o.found = 1'b1;
                    o.status = ST_DONE;
                end
                else
                begin
                    o.kth_key = KEY_NONE;
                    o.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        o.held_count = COUNT_W'(held_keys.size());
        return o;
    endfunction

    function automatic req_t mk_req(logic [1:0] c, logic signed [KEY_BITS-1:0] k, int rk);
        req_t r;
        r.cmd = c;
        r.key = k;
        r.rank = RANK_W'(rk);
        return r;
    endfunction

    function automatic logic signed [KEY_BITS-1:0] rand_key();
        case ($urandom_range(0, 31))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return KEY_NONE;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [KEY_BITS-1:0] pick_held();
        if (held_keys.size() == 0)
            return rand_key();
        return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    function automatic int pick_rank();
        int n;
        n = held_keys.size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return n + $urandom_range(1, 3);
            2: return $urandom_range(0, RANK_MAX);
            3: return 1;
            4: return n;
            default: return (n == 0) ? 1 : $urandom_range(1, n);
        endcase
    endfunction

    // small key pool so inserts collide and removes find their keys
    function automatic req_t mixed_request();
        int sel;
        int sk;
        sel = $urandom_range(0, 19);
        sk = $urandom_range(0, 16);
        sk = sk - 8;
        if (sel < 2)
            return mk_req(CMD_INSERT, rand_key(), $urandom_range(0, RANK_MAX));
        if (sel < 8)
            return mk_req(CMD_INSERT, sk, $urandom_range(0, RANK_MAX));
        if (sel < 13)
            return mk_req(CMD_REMOVE, sk, $urandom_range(0, RANK_MAX));
        if (sel < 19)
            return mk_req(CMD_QUERY, rand_key(), pick_rank());
        return mk_req(CMD_UNUSED, rand_key(), $urandom_range(0, RANK_MAX));
    endfunction

    // mostly fresh inserts until the store is full
    function automatic req_t fill_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 96)
            return mk_req(CMD_INSERT, $urandom, $urandom_range(0, RANK_MAX));
        if (sel < 97)
            return mk_req(CMD_INSERT, pick_held(), $urandom_range(0, RANK_MAX));
        if (sel < 98)
            return mk_req(CMD_REMOVE, pick_held(), $urandom_range(0, RANK_MAX));
        return mk_req(CMD_QUERY, rand_key(), pick_rank());
    endfunction

    // churn around a full store
    function automatic req_t full_request();
        int sel;
        sel = $urandom_range(0, 19);
        if (held_keys.size() < CAPACITY && sel < 10)
            return mk_req(CMD_INSERT, rand_key(), $urandom_range(0, RANK_MAX));
        if (sel < 9)
            return mk_req(CMD_INSERT, rand_key(), $urandom_range(0, RANK_MAX));
        if (sel < 12)
            return mk_req(CMD_INSERT, pick_held(), $urandom_range(0, RANK_MAX));
        if (sel < 15)
            return mk_req(CMD_REMOVE, pick_held(), $urandom_range(0, RANK_MAX));
        if (sel < 16)
            return mk_req(CMD_REMOVE, rand_key(), $urandom_range(0, RANK_MAX));
        return mk_req(CMD_QUERY, rand_key(), pick_rank());
    endfunction

    task automatic add_row(input logic [1:0] c, input logic signed [KEY_BITS-1:0] k,
                           input int rk, input bit typed,
                           input logic signed [KEY_BITS-1:0] kth, input logic fnd,
                           input logic [1:0] st, input int cnt);
        dir_row_t row;
        row.rq = mk_req(c, k, rk);
        row.typed = typed;
        row.want.kth_key = kth;
        row.want.found = fnd;
        row.want.status = st;
        row.want.held_count = COUNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    // directed table: typed replies where obvious, the rest from the set model
    task automatic build_directed_rows();
        add_row(CMD_QUERY,  '0,       1,        1, KEY_NONE, 1'b0, ST_RANGE,   0);
        add_row(CMD_REMOVE, 5,        0,        1, '0,       1'b0, ST_IGNORED, 0);
        add_row(CMD_INSERT, KEY_MAX,  0,        1, '0,       1'b0, ST_DONE,    1);
        add_row(CMD_INSERT, KEY_MIN,  RANK_MAX, 1, '0,       1'b0, ST_DONE,    2);
        add_row(CMD_INSERT, '0,       0,        1, '0,       1'b0, ST_DONE,    3);
        add_row(CMD_INSERT, KEY_NONE, 0,        1, '0,       1'b0, ST_DONE,    4);
        add_row(CMD_INSERT, KEY_MAX,  0,        1, '0,       1'b0, ST_IGNORED, 4);
        add_row(CMD_QUERY,  '0,       1,        1, KEY_MAX,  1'b1, ST_DONE,    4);
        add_row(CMD_QUERY,  KEY_NONE, 4,        1, KEY_MIN,  1'b1, ST_DONE,    4);
        add_row(CMD_QUERY,  '0,       5,        1, KEY_NONE, 1'b0, ST_RANGE,   4);
        add_row(CMD_QUERY,  '0,       0,        1, KEY_NONE, 1'b0, ST_RANGE,   4);
        add_row(CMD_QUERY,  KEY_MAX,  RANK_MAX, 1, KEY_NONE, 1'b0, ST_RANGE,   4);
        add_row(CMD_UNUSED, KEY_MAX,  RANK_MAX, 1, '0,       1'b0, ST_IGNORED, 4);
        add_row(CMD_REMOVE, KEY_NONE, 0,        1, '0,       1'b0, ST_DONE,    3);
        add_row(CMD_REMOVE, KEY_NONE, 0,        1, '0,       1'b0, ST_IGNORED, 3);
        add_row(CMD_QUERY,  '0,       2,        1, '0,       1'b1, ST_DONE,    3);
        add_row(CMD_INSERT, 1,        0,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_INSERT, -2,       0,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_QUERY,  '0,       3,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_REMOVE, KEY_MIN,  0,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_QUERY,  '0,       4,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_REMOVE, KEY_MAX,  0,        0, '0,       1'b0, ST_DONE,    0);
        add_row(CMD_QUERY,  '0,       1,        0, '0,       1'b0, ST_DONE,    0);
    endtask

    // offer one request, honoring the burst gap, and wait for its accept
    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        rsp_t predicted;
        while (gap_left > 0)
        begin
            req_valid <= 1'b0;
            gap_left--;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_set_request(r);
        pending_replies.push_back(typed ? want : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 5);
        end
    endtask

    // request side and end of run
    initial
    begin : drive
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        build_directed_rows();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        repeat (MIXED_ITEMS)
            send_request(mixed_request(), 1'b0, '0);
        while (held_keys.size() < CAPACITY)
            send_request(fill_request(), 1'b0, '0);
        repeat (FULL_ITEMS)
            send_request(full_request(), 1'b0, '0);
        req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // response side: random stall segments plus one long hold-off
    initial
    begin : rsp_side
        int seg_len;
        int mode;
        bit held_off;
        held_off = 1'b0;
        rsp_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && cycle_count >= HOLD_START)
            begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            seg_len = $urandom_range(4, 60);
            mode = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // compare each accepted response with the oldest owed reply
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected response", rsp.kth_key, '0);
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.kth_key !== want.kth_key)
                    report_mismatch("kth_key", rsp.kth_key, want.kth_key);
                if (rsp.found !== want.found)
                    report_mismatch("found", KEY_BITS'(rsp.found), KEY_BITS'(want.found));
                if (rsp.status !== want.status)
                    report_mismatch("status", KEY_BITS'(rsp.status), KEY_BITS'(want.status));
                if (rsp.held_count !== want.held_count)
                    report_mismatch("held_count", KEY_BITS'(rsp.held_count),
                                    KEY_BITS'(want.held_count));
            end
        end
    end

endmodule

FILE: filelist.f
+incdir+design
design/oskl_pkg.sv
design/oskl_cell.sv
design/oskl_reduce.sv
design/ordered_set_kth_largest_top.sv
tb/sv/tb_ordered_set_kth_largest_top.sv
